@@ src/vpd_pkg.sv @@
// shared codes and constants for the vram port with dma
package vpd_pkg;

	localparam int VRAM_ADDR_BITS_DEF = 16;
	localparam int BANK_AW            = 24;
	localparam int IDX_W              = 17;

	// action codes
	localparam logic [1:0] ACT_READ  = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_STEP  = 2'd2;

	// register numbers
	localparam logic [3:0] REG_PTR_LO = 4'd0;
	localparam logic [3:0] REG_PTR_MD = 4'd1;
	localparam logic [3:0] REG_PTR_HI = 4'd2;
	localparam logic [3:0] REG_DATA   = 4'd3;
	localparam logic [3:0] REG_CTRL   = 4'd4;
	localparam logic [3:0] REG_SRC_LO = 4'd5;
	localparam logic [3:0] REG_SRC_MD = 4'd6;
	localparam logic [3:0] REG_SRC_HI = 4'd7;
	localparam logic [3:0] REG_DST_LO = 4'd8;
	localparam logic [3:0] REG_DST_MD = 4'd9;
	localparam logic [3:0] REG_DST_HI = 4'd10;
	localparam logic [3:0] REG_LEN_LO = 4'd11;
	localparam logic [3:0] REG_LEN_HI = 4'd12;

	// control register bit positions
	localparam int CTRL_TRIG = 0;
	localparam int CTRL_DIR  = 1;

	localparam logic [IDX_W-1:0] FULL_BURST = 17'h10000;
	localparam logic [7:0]       NO_DATA    = 8'hFF;

endpackage

@@ src/vram_port_with_dma_top.sv @@
// vram behind a register port, with a byte-stepped dma engine to banked memory
//
// Each transaction on the input channel is one register read, one register write or one dma
// step tick, and yields exactly one transaction on the output channel. Each item first
// registers the vram read (data port or dma source byte), then applies the read-modify-write
// and loads the output register; only one item is in flight, so the single vram read/write
// slot is never shared. A finished result waits in the output register, and the next item is
// still taken while it waits, but that item then holds until the output register frees.
// After reset the vram is cleared by a pass that writes one byte per cycle, covering all
// 2**VRAM_ADDR_BITS bytes, while in_stall stays high. bank_rdata belongs to the read
// requested by the previous dma step and is sampled with the next step item.
module vram_port_with_dma_top import vpd_pkg::*; #(
	parameter int VRAM_ADDR_BITS = VRAM_ADDR_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         action,
	input  logic [3:0]         reg_req,
	input  logic [7:0]         wdata,
	input  logic [7:0]         bank_rdata,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         rdata,
	output logic               busy_res,
	output logic               bank_valid,
	output logic               bank_write,
	output logic [BANK_AW-1:0] bank_addr,
	output logic [7:0]         bank_wdata,
	output logic               dma_done
);

	localparam int VA         = VRAM_ADDR_BITS;
	localparam int VRAM_DEPTH = 1 << VRAM_ADDR_BITS;

	// vram storage, one read and one write port
	logic [7:0] vram_mem [VRAM_DEPTH];

	// clearing pass after reset
	logic          clearing_q;
	logic [VA-1:0] clr_addr_q;

	// architectural state
	logic [BANK_AW-1:0] ptr_q, src_q, dst_q;
	logic [15:0]        len_q;
	logic               busy_q, dir_q, pend_q;
	logic [IDX_W-1:0]   idx_q, total_q;

	// next state
	logic [BANK_AW-1:0] ptr_d, src_d, dst_d;
	logic [15:0]        len_d;
	logic               busy_d, dir_d, pend_d;
	logic [IDX_W-1:0]   idx_d, total_d;

	// item under execution
	logic               valid_s1;
	logic [1:0]         action_s1;
	logic [3:0]         reg_s1;
	logic [7:0]         wdata_s1;
	logic [7:0]         brd_s1;
	logic [7:0]         rd_s1;

	// output register
	logic               out_valid_q;
	logic [7:0]         rdata_q, bwdata_q;
	logic               busy_res_q, bvalid_q, bwrite_q, done_q;
	logic [BANK_AW-1:0] baddr_q;

	// results computed for the item in s1
	logic [7:0]         r_rdata, r_bwdata;
	logic               r_bvalid, r_bwrite, r_done;
	logic [BANK_AW-1:0] r_baddr;

	logic          accept, complete;
	logic [VA-1:0] raddr, waddr, ptr_addr, ptr_addr_inc;
	logic [VA-1:0] src_idx_addr, dst_idx_m1_addr;
	logic [BANK_AW-1:0] src_plus_idx, dst_plus_idx;
	logic [IDX_W-1:0]   idx_inc;
	logic [7:0]    wbyte;
	logic          we;

	// one item at a time; no items during the clearing pass
	assign in_stall = clearing_q | valid_s1;
	assign accept   = in_valid & ~in_stall;
	assign complete = valid_s1 & (~out_valid_q | ~out_stall);

	// address arithmetic
	assign ptr_addr        = ptr_q[VA-1:0];
	assign ptr_addr_inc    = ptr_addr + VA'(1);
	assign src_plus_idx    = src_q + BANK_AW'(idx_q);
	assign dst_plus_idx    = dst_q + BANK_AW'(idx_q);
	assign src_idx_addr    = src_plus_idx[VA-1:0];
	assign dst_idx_m1_addr = VA'(dst_plus_idx - BANK_AW'(1));
	assign idx_inc         = idx_q + IDX_W'(1);

	// read address chosen at accept: a step reads the dma source byte, else the pointer byte
	assign raddr = (action == ACT_STEP) ? src_idx_addr : ptr_addr;

	// vram ports: the clearing pass owns the write port until it ends
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			vram_mem[clr_addr_q] <= 8'd0;
		end else if (complete && we) begin
			vram_mem[waddr] <= wbyte;
		end
		if (accept) begin
			rd_s1 <= vram_mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + VA'(1);
			if (&clr_addr_q) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// capture the accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (complete) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= action;
			reg_s1    <= reg_req;
			wdata_s1  <= wdata;
			brd_s1    <= bank_rdata;
		end
	end

	// execute: register decode and one dma byte step
	always_comb begin
		ptr_d    = ptr_q;
		src_d    = src_q;
		dst_d    = dst_q;
		len_d    = len_q;
		busy_d   = busy_q;
		dir_d    = dir_q;
		pend_d   = pend_q;
		idx_d    = idx_q;
		total_d  = total_q;
		we       = 1'b0;
		waddr    = ptr_addr;
		wbyte    = wdata_s1;
		r_rdata  = NO_DATA;
		r_bvalid = 1'b0;
		r_bwrite = 1'b0;
		r_baddr  = '0;
		r_bwdata = 8'd0;
		r_done   = 1'b0;
		case (action_s1)
			ACT_READ: begin
				case (reg_s1)
					REG_PTR_LO: r_rdata = ptr_q[7:0];
					REG_PTR_MD: r_rdata = ptr_q[15:8];
					REG_PTR_HI: r_rdata = ptr_q[23:16];
					REG_DATA: begin
						r_rdata = rd_s1;
						ptr_d   = BANK_AW'(ptr_addr_inc);
					end
					REG_CTRL:   r_rdata = {6'd0, dir_q, busy_q};
					REG_SRC_LO: r_rdata = src_q[7:0];
					REG_SRC_MD: r_rdata = src_q[15:8];
					REG_SRC_HI: r_rdata = src_q[23:16];
					REG_DST_LO: r_rdata = dst_q[7:0];
					REG_DST_MD: r_rdata = dst_q[15:8];
					REG_DST_HI: r_rdata = dst_q[23:16];
					REG_LEN_LO: r_rdata = len_q[7:0];
					REG_LEN_HI: r_rdata = len_q[15:8];
					default:    r_rdata = NO_DATA;
				endcase
			end
			ACT_WRITE: begin
				case (reg_s1)
					REG_PTR_LO: ptr_d[7:0]   = wdata_s1;
					REG_PTR_MD: ptr_d[15:8]  = wdata_s1;
					REG_PTR_HI: ptr_d[23:16] = wdata_s1;
					REG_DATA: begin
						we    = 1'b1;
						ptr_d = BANK_AW'(ptr_addr_inc);
					end
					default: begin
						// dma setup registers are locked while a transfer runs
						if (!busy_q) begin
							case (reg_s1)
								REG_CTRL: begin
									if (wdata_s1[CTRL_TRIG]) begin
										dir_d   = wdata_s1[CTRL_DIR];
										total_d = (len_q == 16'd0) ? FULL_BURST
										                           : IDX_W'(len_q);
										idx_d   = '0;
										pend_d  = 1'b0;
										busy_d  = 1'b1;
									end
								end
								REG_SRC_LO: src_d[7:0]   = wdata_s1;
								REG_SRC_MD: src_d[15:8]  = wdata_s1;
								REG_SRC_HI: src_d[23:16] = wdata_s1;
								REG_DST_LO: dst_d[7:0]   = wdata_s1;
								REG_DST_MD: dst_d[15:8]  = wdata_s1;
								REG_DST_HI: dst_d[23:16] = wdata_s1;
								REG_LEN_LO: len_d[7:0]   = wdata_s1;
								REG_LEN_HI: len_d[15:8]  = wdata_s1;
								default: ;
							endcase
						end
					end
				endcase
			end
			ACT_STEP: begin
				if (busy_q) begin
					if (!dir_q) begin
						// vram to bank: push one byte per step
						r_bvalid = 1'b1;
						r_bwrite = 1'b1;
						r_baddr  = dst_plus_idx;
						r_bwdata = rd_s1;
						idx_d    = idx_inc;
						if (idx_inc >= total_q) begin
							busy_d = 1'b0;
							r_done = 1'b1;
						end
					end else begin
						// bank to vram: retire last read, then issue the next one
						if (pend_q) begin
							we    = 1'b1;
							waddr = dst_idx_m1_addr;
							wbyte = brd_s1;
						end
						if (idx_q < total_q) begin
							r_bvalid = 1'b1;
							r_baddr  = src_plus_idx;
							idx_d    = idx_inc;
							pend_d   = 1'b1;
						end else begin
							pend_d = 1'b0;
							busy_d = 1'b0;
							r_done = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			src_q   <= '0;
			dst_q   <= '0;
			len_q   <= '0;
			busy_q  <= 1'b0;
			dir_q   <= 1'b0;
			pend_q  <= 1'b0;
			idx_q   <= '0;
			total_q <= '0;
		end else if (complete) begin
			ptr_q   <= ptr_d;
			src_q   <= src_d;
			dst_q   <= dst_d;
			len_q   <= len_d;
			busy_q  <= busy_d;
			dir_q   <= dir_d;
			pend_q  <= pend_d;
			idx_q   <= idx_d;
			total_q <= total_d;
		end
	end

	// output register: loads on completion, holds while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (complete) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (complete) begin
			rdata_q    <= r_rdata;
			busy_res_q <= busy_d;
			bvalid_q   <= r_bvalid;
			bwrite_q   <= r_bwrite;
			baddr_q    <= r_baddr;
			bwdata_q   <= r_bwdata;
			done_q     <= r_done;
		end
	end

	assign out_valid  = out_valid_q;
	assign rdata      = rdata_q;
	assign busy_res   = busy_res_q;
	assign bank_valid = bvalid_q;
	assign bank_write = bwrite_q;
	assign bank_addr  = baddr_q;
	assign bank_wdata = bwdata_q;
	assign dma_done   = done_q;

endmodule

@@ src/vpd_checker.sv @@
// port-level checks for the vram port with dma, bound to the top level
module vpd_checker import vpd_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [7:0]         rdata,
	input logic               busy_res,
	input logic               bank_valid,
	input logic               bank_write,
	input logic [BANK_AW-1:0] bank_addr,
	input logic [7:0]         bank_wdata,
	input logic               dma_done
);

	// one transaction in flight: an accept is followed by a stall
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while previous transaction still executing");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(rdata) && $stable(bank_addr)
			&& $stable(dma_done) && $stable(busy_res))
		else $error("stalled result changed");

	// no bank request means an all-zero request
	a_idle_bank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !bank_valid |-> !bank_write && bank_addr == '0 && bank_wdata == 8'd0)
		else $error("bank fields set without a request");

	// finishing a transfer leaves the engine idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dma_done |-> !busy_res)
		else $error("dma done reported while still busy");

	// bank traffic only on step results, which never carry read data
	a_bank_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (bank_valid || dma_done) |-> rdata == NO_DATA)
		else $error("bank request on a register transaction");

endmodule

bind vram_port_with_dma_top vpd_checker u_vpd_checker (.*);
